@@ design/assert_macros.svh @@
// Assertion macros shared by the top level and the box store of the bounding box accumulator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checks that a property holds at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checks that a consequent holds whenever an antecedent holds.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Checks that a consequent holds in the cycle after an antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ design/bbox_pkg.sv @@
// Types, codes and helper functions of the bounding box accumulator.
package bbox_pkg;

  localparam int LABEL_COUNT = 256;
  localparam int FID_W       = 9;
  localparam int LABEL_W     = FID_W - 1;
  localparam int COORD_W     = 32;
  localparam int SPACING_W   = 31;
  localparam int CFG_INDEX_W = 3;

  localparam logic [1:0] OP_ACC   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_GRID_MODE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SPACING_X = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPACING_Y = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPACING_Z = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Z  = 3'd6;

  localparam logic [SPACING_W-1:0] SPACING_RESET = 31'd65536;

  typedef struct packed {
    logic signed [COORD_W-1:0] max_z;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_x;
  } box_t;

  typedef struct packed {
    logic               rd_en;
    logic               wr_en;
    logic               set_touched;
    logic               clear_all;
    logic [LABEL_W-1:0] addr;
    box_t               wdata;
  } store_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_BASE,
    ST_MERGE,
    ST_READ
  } state_t;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
    if (v[63:COORD_W-1] == {(64-COORD_W+1){v[63]}}) begin
      return v[COORD_W-1:0];
    end else if (v[63]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

@@ design/per_label_bounding_box_accumulator_top.sv @@
// Top level of the per-label bounding box accumulator.
// The input stream carries one operation per transaction: accumulate a point into
// the box of its label, read the box of a label, or clear every box. The operation
// code travels in s_axis_tuser, the label and point in s_axis_tdata. Reads return
// one transaction on the output stream with box_valid in m_axis_tuser and the six
// box bounds in m_axis_tdata; accumulate and clear return nothing.
// Items are handled one at a time. An accumulate steps through accept, multiply,
// add origin, merge and write back, paced by the span product and base registers
// ahead of the box memory read-modify-write. A read uses the registered memory
// read, then waits for the output register; a clear or ignored item ends on accept.
// The result sits in an output register, so a new item is accepted while a read
// result still waits; a second read holds until the receiver takes the first.
// Reset empties all boxes at once and restores the configuration defaults; the
// box memory itself keeps stale data that is never shown for an empty label.
// Configuration writes are always ready and must come only while the block idles.
`include "assert_macros.svh"
module per_label_bounding_box_accumulator_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // feature_id [8:0], pos_x [40:9], pos_y [72:41], pos_z [104:73], zero fill above
  input  logic [111:0]                        s_axis_tdata,
  // op [1:0]
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // min_x [31:0], min_y [63:32], min_z [95:64], max_x [127:96], max_y [159:128],
  // max_z [191:160]
  output logic [191:0]                        m_axis_tdata,
  // box_valid
  output logic                                m_axis_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bbox_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [31:0]                         cfg_data
);

  localparam int CW = bbox_pkg::COORD_W;

  bbox_pkg::state_t     state, state_next;
  bbox_pkg::store_req_t req;
  bbox_pkg::box_t       rd_data, merged;
  logic                 touched_bit;

  logic                          grid_mode;
  logic [bbox_pkg::SPACING_W-1:0] spacing_x, spacing_y, spacing_z;
  logic signed [CW-1:0]          origin_x, origin_y, origin_z;

  logic [1:0]                       in_op;
  logic [bbox_pkg::FID_W-1:0]       in_fid;
  logic                             s_accept;
  logic                             in_table_in;

  logic [bbox_pkg::FID_W-1:0]       item_fid;
  logic signed [CW-1:0]             item_x, item_y, item_z;
  logic                             item_in_table;

  logic signed [CW-1:0]             lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  logic                             out_load;
  logic                             read_valid;

  assign in_op       = s_axis_tuser;
  assign in_fid      = s_axis_tdata[8:0];
  assign s_accept    = s_axis_tvalid && s_axis_tready;
  assign in_table_in = !in_fid[bbox_pkg::FID_W-1];
  assign cfg_ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_mode <= 1'b0;
      spacing_x <= bbox_pkg::SPACING_RESET;
      spacing_y <= bbox_pkg::SPACING_RESET;
      spacing_z <= bbox_pkg::SPACING_RESET;
      origin_x  <= '0;
      origin_y  <= '0;
      origin_z  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bbox_pkg::REG_GRID_MODE: grid_mode <= cfg_data[0];
        bbox_pkg::REG_SPACING_X: spacing_x <= cfg_data[bbox_pkg::SPACING_W-1:0];
        bbox_pkg::REG_SPACING_Y: spacing_y <= cfg_data[bbox_pkg::SPACING_W-1:0];
        bbox_pkg::REG_SPACING_Z: spacing_z <= cfg_data[bbox_pkg::SPACING_W-1:0];
        bbox_pkg::REG_ORIGIN_X:  origin_x  <= $signed(cfg_data);
        bbox_pkg::REG_ORIGIN_Y:  origin_y  <= $signed(cfg_data);
        bbox_pkg::REG_ORIGIN_Z:  origin_z  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      item_fid <= in_fid;
      item_x   <= $signed(s_axis_tdata[40:9]);
      item_y   <= $signed(s_axis_tdata[72:41]);
      item_z   <= $signed(s_axis_tdata[104:73]);
    end
  end

  assign item_in_table = !item_fid[bbox_pkg::FID_W-1];

  bbox_span u_span_x (
    .clk(clk), .grid_mode(grid_mode), .coord(item_x), .spacing(spacing_x),
    .origin(origin_x), .lo(lo_x), .hi(hi_x)
  );
  bbox_span u_span_y (
    .clk(clk), .grid_mode(grid_mode), .coord(item_y), .spacing(spacing_y),
    .origin(origin_y), .lo(lo_y), .hi(hi_y)
  );
  bbox_span u_span_z (
    .clk(clk), .grid_mode(grid_mode), .coord(item_z), .spacing(spacing_z),
    .origin(origin_z), .lo(lo_z), .hi(hi_z)
  );

  bbox_store u_store (
    .clk(clk), .rst(rst), .req(req), .rd_data(rd_data), .touched_bit(touched_bit)
  );

  // The first point of a label sets its box; later points widen it.
  always_comb begin
    if (!touched_bit) begin
      merged = '{max_z: hi_z, max_y: hi_y, max_x: hi_x,
                 min_z: lo_z, min_y: lo_y, min_x: lo_x};
    end else begin
      merged.min_x = (lo_x < rd_data.min_x) ? lo_x : rd_data.min_x;
      merged.min_y = (lo_y < rd_data.min_y) ? lo_y : rd_data.min_y;
      merged.min_z = (lo_z < rd_data.min_z) ? lo_z : rd_data.min_z;
      merged.max_x = (hi_x > rd_data.max_x) ? hi_x : rd_data.max_x;
      merged.max_y = (hi_y > rd_data.max_y) ? hi_y : rd_data.max_y;
      merged.max_z = (hi_z > rd_data.max_z) ? hi_z : rd_data.max_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bbox_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bbox_pkg::ST_IDLE: begin
        if (s_accept) begin
          case (in_op)
            bbox_pkg::OP_ACC:  state_next = in_table_in ? bbox_pkg::ST_MUL : bbox_pkg::ST_IDLE;
            bbox_pkg::OP_READ: state_next = bbox_pkg::ST_READ;
            default:           state_next = bbox_pkg::ST_IDLE;
          endcase
        end
      end
      bbox_pkg::ST_MUL:   state_next = bbox_pkg::ST_BASE;
      bbox_pkg::ST_BASE:  state_next = bbox_pkg::ST_MERGE;
      bbox_pkg::ST_MERGE: state_next = bbox_pkg::ST_IDLE;
      bbox_pkg::ST_READ: begin
        if (out_load) begin
          state_next = bbox_pkg::ST_IDLE;
        end
      end
      default: state_next = bbox_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready   = (state == bbox_pkg::ST_IDLE);
    req.addr        = (state == bbox_pkg::ST_IDLE) ? in_fid[bbox_pkg::LABEL_W-1:0]
                                                   : item_fid[bbox_pkg::LABEL_W-1:0];
    req.rd_en       = s_accept && (in_op == bbox_pkg::OP_ACC || in_op == bbox_pkg::OP_READ);
    req.wr_en       = (state == bbox_pkg::ST_MERGE);
    req.set_touched = (state == bbox_pkg::ST_MERGE);
    req.clear_all   = s_accept && (in_op == bbox_pkg::OP_CLEAR);
    req.wdata       = merged;
    out_load        = (state == bbox_pkg::ST_READ) && (!m_axis_tvalid || m_axis_tready);
  end

  assign read_valid = item_in_table && touched_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tuser <= read_valid;
      m_axis_tdata <= read_valid ? rd_data : '0;
    end
  end

  `ASSERT_NEXT(a_acc_starts, clk, rst,
    s_accept && in_op == bbox_pkg::OP_ACC && in_table_in, state == bbox_pkg::ST_MUL,
    "accumulate did not start the span datapath")
  `ASSERT_IMPLY(a_merge_order, clk, rst, state == bbox_pkg::ST_MERGE,
    $past(state) == bbox_pkg::ST_BASE, "merge reached without the base stage")
  `ASSERT_IMPLY(a_result_from_read, clk, rst, $rose(m_axis_tvalid),
    $past(state) == bbox_pkg::ST_READ, "result produced outside a read")
  `ASSERT_IMPLY(a_empty_reads_zero, clk, rst, m_axis_tvalid && !m_axis_tuser,
    m_axis_tdata == '0, "empty box returned nonzero bounds")

endmodule

@@ design/bbox_store.sv @@
// Box memory with registered read, plus the per-label touched bits.
`include "assert_macros.svh"
module bbox_store (
  input  logic                  clk,
  input  logic                  rst,
  input  bbox_pkg::store_req_t  req,
  output bbox_pkg::box_t        rd_data,
  output logic                  touched_bit
);

  bbox_pkg::box_t                     box_mem [bbox_pkg::LABEL_COUNT];
  logic [bbox_pkg::LABEL_COUNT-1:0]   touched;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      box_mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_data <= box_mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      touched <= '0;
    end else if (req.clear_all) begin
      touched <= '0;
    end else if (req.set_touched) begin
      touched[req.addr] <= 1'b1;
    end
  end

  assign touched_bit = touched[req.addr];

  `ASSERT_NEXT(a_clear_empties, clk, rst, req.clear_all, touched == '0, "clear left a touched bit")
  `ASSERT_IMPLY(a_no_rw_clear, clk, rst, req.clear_all, !req.wr_en && !req.set_touched, "clear overlaps a write")

endmodule

@@ design/bbox_span.sv @@
// One axis's cell span: registered product and base, low and high ends saturated in grid mode.
module bbox_span (
  input  logic                                 clk,
  input  logic                                 grid_mode,
  input  logic signed [bbox_pkg::COORD_W-1:0]  coord,
  input  logic [bbox_pkg::SPACING_W-1:0]       spacing,
  input  logic signed [bbox_pkg::COORD_W-1:0]  origin,
  output logic signed [bbox_pkg::COORD_W-1:0]  lo,
  output logic signed [bbox_pkg::COORD_W-1:0]  hi
);

  logic signed [63:0] prod;
  logic signed [63:0] base;
  logic signed [63:0] top_sum;

  always_ff @(posedge clk) begin
    prod <= 64'(coord) * 64'($signed({1'b0, spacing}));
    base <= prod + 64'(origin);
  end

  assign top_sum = base + $signed({33'b0, spacing});
  assign lo = grid_mode ? bbox_pkg::sat32(base) : coord;
  assign hi = grid_mode ? bbox_pkg::sat32(top_sum) : coord;

endmodule
